// ----- src/rrov_pkg.sv -----
// Shared types, constants and tables for the rounded-rect outline vertex generator.
package rrov_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int CoordW   = 20;
  localparam int ColorW   = 32;
  localparam int IndexW   = 10;
  localparam int QualW    = 11;
  localparam int RadW     = 18;
  localparam int DimW     = 19;
  // CORDIC datapath width: radius*K*2^8 stays below 2^26, growth below 2^27.
  localparam int CordW    = 30;
  localparam int PhaseW   = 32;
  localparam int AngW     = 34;
  localparam int AtanEntries = 24;
  localparam logic [63:0] GainQ32 = 64'd2608131496;

  localparam logic [CfgIdxW-1:0] REG_SHAPE_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_POS_X       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_POS_Y       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RECT_WIDTH  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RECT_HEIGHT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ARC_RADIUS  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_QUALITY     = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_FILL_COLOR  = 3'd7;

  function automatic logic [PhaseW-1:0] atan_turn(input int k);
    logic [PhaseW-1:0] v;
    case (k)
      0: v = 32'h20000000;  1: v = 32'h12E4051D;  2: v = 32'h09FB385B;
      3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
      6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
      9: v = 32'h00145F2E; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
      12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2F9;
      15: v = 32'h0000517C; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
      18: v = 32'h00000A2F; 19: v = 32'h00000517; 20: v = 32'h0000028B;
      21: v = 32'h00000145; 22: v = 32'h000000A2; 23: v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Per-vertex side data that rides along the CORDIC chain.
  typedef struct packed {
    logic              ok;
    logic [1:0]        quad;
    logic signed [21:0] off_x;
    logic signed [21:0] off_y;
    logic [ColorW-1:0] color;
  } side_t;

  typedef struct packed {
    logic               vld;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
    side_t              side;
  } cell_t;

endpackage

// ----- src/rrov_if.sv -----
// Valid/ready stream interfaces for vertex indices and vertices.
interface rrov_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] vertex_index;
  modport source (output valid, output vertex_index, input ready);
  modport sink   (input valid, input vertex_index, output ready);
endinterface

interface rrov_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] vertex_x;
  logic [19:0] vertex_y;
  logic [31:0] vertex_color;
  logic        index_valid;
  modport source (output valid, output vertex_x, output vertex_y, output vertex_color,
                  output index_valid, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input vertex_color,
                  input index_valid, output ready);
endinterface

// ----- src/rrov_phase.sv -----
// Phase divider: index*2^32/q by restoring division, one quotient bit per cell.
module rrov_phase #(
  parameter int QW = 11,
  parameter int NW = 42,
  parameter int PW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [QW-1:0] in_den,
  input  rrov_pkg::side_t in_side,
  output logic          out_vld,
  output logic [PW-1:0] out_quo,
  output rrov_pkg::side_t out_side
);
  import rrov_pkg::*;

  // Only the low PW quotient bits are kept; the higher ones are zero only when index < q.
  logic          vld_r  [PW+1];
  logic [QW:0]   rem_r  [PW+1];
  logic [NW-1:0] num_r  [PW+1];
  logic [PW-1:0] quo_r  [PW+1];
  logic [QW-1:0] den_r  [PW+1];
  side_t         side_r [PW+1];

  always_comb begin
    vld_r[0]  = in_vld;
    num_r[0]  = in_num;
    den_r[0]  = in_den;
    side_r[0] = in_side;
    quo_r[0]  = '0;
    // the index part sits above the PW fraction bits and starts as the remainder
    rem_r[0]  = (QW+1)'(in_num[NW-1:PW]);
  end

  for (genvar i = 0; i < PW; i++) begin : g_cell
    logic [QW+1:0] trial;
    logic [QW:0]   rem_nxt;
    logic [QW+1:0] shifted;
    // remainder before this bit is the top part; bring the next numerator bit in
    assign shifted = {rem_r[i], num_r[i][PW-1-i]};
    assign trial   = shifted - {2'b0, den_r[i]};
    assign rem_nxt = trial[QW+1] ? shifted[QW:0] : trial[QW:0];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        rem_r[i+1]  <= rem_nxt;
        num_r[i+1]  <= num_r[i];
        den_r[i+1]  <= den_r[i];
        side_r[i+1] <= side_r[i];
        quo_r[i+1]  <= {quo_r[i][PW-2:0], ~trial[QW+1]};
      end
    end
  end

  assign out_vld  = vld_r[PW];
  assign out_quo  = quo_r[PW];
  assign out_side = side_r[PW];
endmodule

// ----- src/rrov_cordic_cell.sv -----
// One rotation-mode CORDIC cell with a register on its output.
module rrov_cordic_cell #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  rrov_pkg::cell_t in_c,
  output rrov_pkg::cell_t out_c
);
  import rrov_pkg::*;

  cell_t c_r;
  cell_t c_nxt;
  logic signed [CordW-1:0] xs;
  logic signed [CordW-1:0] ys;
  logic signed [AngW-1:0]  a;

  always_comb begin
    xs = in_c.x >>> K;
    ys = in_c.y >>> K;
    a  = $signed({2'b00, atan_turn(K)});
    c_nxt = in_c;
    if (!in_c.z[AngW-1]) begin
      c_nxt.x = in_c.x - ys;
      c_nxt.y = in_c.y + xs;
      c_nxt.z = in_c.z - a;
    end else begin
      c_nxt.x = in_c.x + ys;
      c_nxt.y = in_c.y - xs;
      c_nxt.z = in_c.z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (en) begin
      c_r.vld <= c_nxt.vld;
    end
    if (en) begin
      c_r.x    <= c_nxt.x;
      c_r.y    <= c_nxt.y;
      c_r.z    <= c_nxt.z;
      c_r.side <= c_nxt.side;
    end
  end

  assign out_c = c_r;
endmodule

// ----- src/rounded_rect_outline_vertex_gen.sv -----
// Top level: config registers, front end, divider and CORDIC cell chains, output stage.
//   channel | dir | beat                                   | handshake
//   in_*    | in  | vertex_index                           | in_valid & in_ready
//   out_*   | out | vertex_x, vertex_y, vertex_color, ok   | out_valid & out_ready
//   cfg_*   | in  | cfg_index, cfg_data                    | cfg_we
// One vertex enters per cycle while the chain advances; it passes two front stages, 32 divider
// cells, min(CORDIC_STAGES, AtanEntries) CORDIC cells and 1 output register. The chain advances
// when the output register is empty or being taken, so a stalled output holds every cell in place.
// Reset clears all valid flags and loads the register reset values.
module rounded_rect_outline_vertex_gen #(
  parameter int MAX_QUALITY   = 1024,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  rrov_in_if.sink    in_ch,
  rrov_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [rrov_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rrov_pkg::CfgDataW-1:0] cfg_data
);
  import rrov_pkg::*;

  localparam int NStage = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int NumW = IndexW + PhaseW;

  logic                 shape_r;
  logic [CoordW-1:0]    pos_x_r, pos_y_r;
  logic [DimW-1:0]      width_r, height_r;
  logic [RadW-1:0]      radius_r;
  logic [QualW-1:0]     quality_r;
  logic [ColorW-1:0]    color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= 1'b0; pos_x_r <= '0; pos_y_r <= '0; width_r <= '0;
      height_r <= '0; radius_r <= '0; quality_r <= 11'd64; color_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHAPE_MODE:  shape_r   <= cfg_data[0];
        REG_POS_X:       pos_x_r   <= cfg_data[CoordW-1:0];
        REG_POS_Y:       pos_y_r   <= cfg_data[CoordW-1:0];
        REG_RECT_WIDTH:  width_r   <= cfg_data[DimW-1:0];
        REG_RECT_HEIGHT: height_r  <= cfg_data[DimW-1:0];
        REG_ARC_RADIUS:  radius_r  <= cfg_data[RadW-1:0];
        REG_QUALITY:     quality_r <= cfg_data[QualW-1:0];
        REG_FILL_COLOR:  color_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective quality and quarter span
  logic [QualW-1:0] q_eff, q_quarter;
  always_comb begin
    if (quality_r < QualW'(4)) q_eff = QualW'(4);
    else if (32'(quality_r) > MAX_QUALITY) q_eff = QualW'(MAX_QUALITY);
    else q_eff = quality_r;
    q_quarter = q_eff >> 2;
  end

  // Output register and chain enable
  logic out_vld_r;
  logic en;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Front stage 1: register index
  logic              s1_vld_r;
  logic [IndexW-1:0] s1_idx_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_ch.valid;
    if (en) s1_idx_r <= in_ch.vertex_index;
  end

  // Corner count: index / (q/4) by at most three compare steps, clamped to 3.
  logic [1:0] corner;
  logic [QualW+1:0] t1, t2, t3;
  always_comb begin
    t1 = {2'b0, q_quarter};
    t2 = t1 + {2'b0, q_quarter};
    t3 = t2 + {2'b0, q_quarter};
    if ({4'b0, s1_idx_r} < t1) corner = 2'd0;
    else if ({4'b0, s1_idx_r} < t2) corner = 2'd1;
    else if ({4'b0, s1_idx_r} < t3) corner = 2'd2;
    else corner = 2'd3;
  end

  side_t s1_side;
  always_comb begin
    logic signed [21:0] wr, hr, rr;
    wr = $signed({3'b0, width_r}) - $signed({4'b0, radius_r});
    hr = $signed({3'b0, height_r}) - $signed({4'b0, radius_r});
    rr = $signed({4'b0, radius_r});
    s1_side.ok    = {1'b0, s1_idx_r} < q_eff;
    s1_side.quad  = 2'd0;
    s1_side.color = color_r;
    s1_side.off_x = 22'(signed'(pos_x_r));
    s1_side.off_y = 22'(signed'(pos_y_r));
    if (shape_r) begin
      s1_side.off_x = s1_side.off_x + ((corner == 2'd0 || corner == 2'd3) ? wr : rr);
      s1_side.off_y = s1_side.off_y + ((corner <= 2'd1) ? hr : rr);
    end
  end

  // Stage 2: register numerator, denominator, side data
  logic             s2_vld_r;
  logic [NumW-1:0]  s2_num_r;
  logic [QualW-1:0] s2_den_r;
  side_t            s2_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
    if (en) begin
      s2_num_r  <= {s1_idx_r, {PhaseW{1'b0}}};
      s2_den_r  <= q_eff;
      s2_side_r <= s1_side;
    end
  end

  logic              dv_vld;
  logic [PhaseW-1:0] dv_quo;
  side_t             dv_side;
  rrov_phase #(.QW(QualW), .NW(NumW), .PW(PhaseW)) u_phase (
    .clk, .rst_n, .en,
    .in_vld(s2_vld_r), .in_num(s2_num_r), .in_den(s2_den_r), .in_side(s2_side_r),
    .out_vld(dv_vld), .out_quo(dv_quo), .out_side(dv_side)
  );

  // CORDIC seed: x0 = floor(r * K_q32 >> 24)
  cell_t chain [NStage+1];
  logic [63:0] seed;
  always_comb begin
    seed = (64'(radius_r) * GainQ32) >> 24;
    chain[0].vld = dv_vld;
    chain[0].x   = CordW'(seed);
    chain[0].y   = '0;
    chain[0].z   = AngW'({2'b00, dv_quo[PhaseW-3:0]});
    chain[0].side = dv_side;
    chain[0].side.quad = dv_quo[PhaseW-1 -: 2];
  end

  for (genvar k = 0; k < NStage; k++) begin : g_cordic
    rrov_cordic_cell #(.K(k)) u_cell (.clk, .rst_n, .en, .in_c(chain[k]), .out_c(chain[k+1]));
  end

  // Quadrant fold, round, offset, saturate
  cell_t fin;
  assign fin = chain[NStage];
  logic signed [CordW:0] c_raw, s_raw;
  logic signed [CordW-8:0] c_rnd, s_rnd;
  logic signed [CordW:0] vx, vy;
  logic [CoordW-1:0] vx_sat, vy_sat;
  always_comb begin
    case (fin.side.quad)
      2'd0: begin c_raw = fin.x;  s_raw = fin.y;  end
      2'd1: begin c_raw = -fin.y; s_raw = fin.x;  end
      2'd2: begin c_raw = -fin.x; s_raw = -fin.y; end
      default: begin c_raw = fin.y; s_raw = -fin.x; end
    endcase
    c_rnd = (CordW-7)'((c_raw + 31'sd128) >>> 8);
    s_rnd = (CordW-7)'((s_raw + 31'sd128) >>> 8);
    vx = (CordW+1)'(c_rnd) + (CordW+1)'(fin.side.off_x);
    vy = (CordW+1)'(s_rnd) + (CordW+1)'(fin.side.off_y);
    if (vx > 31'sd524287) vx_sat = 20'h7FFFF;
    else if (vx < -31'sd524288) vx_sat = 20'h80000;
    else vx_sat = vx[CoordW-1:0];
    if (vy > 31'sd524287) vy_sat = 20'h7FFFF;
    else if (vy < -31'sd524288) vy_sat = 20'h80000;
    else vy_sat = vy[CoordW-1:0];
  end

  logic [CoordW-1:0] ox_r, oy_r;
  logic [ColorW-1:0] ocol_r;
  logic              ook_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= fin.vld;
    if (en) begin
      ox_r   <= fin.side.ok ? vx_sat : '0;
      oy_r   <= fin.side.ok ? vy_sat : '0;
      ocol_r <= fin.side.color;
      ook_r  <= fin.side.ok;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.vertex_x     = ox_r;
  assign out_ch.vertex_y     = oy_r;
  assign out_ch.vertex_color = ocol_r;
  assign out_ch.index_valid  = ook_r;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(ox_r)) else $error("stall lost beat");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_vld_r || out_ch.ready)) else $error("ready mismatch");
  a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !ook_r |-> ox_r == '0 && oy_r == '0) else $error("invalid not zero");
`endif
endmodule

// ----- bench/tb_rounded_rect_outline_vertex_gen.sv -----
// Self-checking testbench for the circle / rounded-rectangle outline vertex generator.
module tb_rounded_rect_outline_vertex_gen;
  timeunit 1ns;
  timeprecision 1ps;
  import rrov_pkg::*;

  localparam int NumStages  = 16;
  localparam int MaxQual    = 1024;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
    logic              ok;
  } vertex_t;

  class vertex_scoreboard;
    logic              mode;
    logic [19:0]       px, py;
    logic [18:0]       rw, rh;
    logic [17:0]       rad;
    logic [10:0]       qual;
    logic [31:0]       color;
    vertex_t           pending_q[$];
    int                errors;
    logic [31:0]       atan_q32[NumStages];

    function new();
      atan_q32 = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
                   32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                   32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
                   32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};
      mode = 0; px = 0; py = 0; rw = 0; rh = 0; rad = 0;
      qual = 64; color = 32'hFFFFFFFF; errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] d);
      case (idx)
        REG_SHAPE_MODE:  mode  = d[0];
        REG_POS_X:       px    = d[19:0];
        REG_POS_Y:       py    = d[19:0];
        REG_RECT_WIDTH:  rw    = d[18:0];
        REG_RECT_HEIGHT: rh    = d[18:0];
        REG_ARC_RADIUS:  rad   = d[17:0];
        REG_QUALITY:     qual  = d[10:0];
        default:         color = d;
      endcase
    endfunction

    function int eff_quality();
      int q;
      q = qual;
      if (q < 4) q = 4;
      if (q > MaxQual) q = MaxQual;
      return q;
    endfunction

    function logic [19:0] sat20(longint v);
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return v[19:0];
    endfunction

    function vertex_t rotate_vertex(logic [9:0] idx);
      vertex_t     v;
      longint      q, x, y, z, xs, ys, c, s, vx, vy, r, corner;
      logic [63:0] ph64;
      logic [31:0] phase;
      q = eff_quality();
      v.color = color;
      if (idx >= q) begin
        v.x = 0; v.y = 0; v.ok = 0;
        return v;
      end
      ph64  = (64'(idx) << 32) / 64'(q);
      phase = ph64[31:0];
      z = longint'(phase[29:0]);
      r = longint'(rad);
      x = longint'((64'(rad) * GainQ32) >> 24);
      y = 0;
      for (int k = 0; k < NumStages; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'(atan_q32[k]);
        end else begin
          x = x + ys; y = y - xs; z = z + longint'(atan_q32[k]);
        end
      end
      case (phase[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      c = (c + 128) >>> 8;
      s = (s + 128) >>> 8;
      vx = longint'($signed(px)) + c;
      vy = longint'($signed(py)) + s;
      if (mode) begin
        corner = idx / (q / 4);
        if (corner > 3) corner = 3;
        vx += (corner == 0 || corner == 3) ? (longint'(rw) - r) : r;
        vy += (corner <= 1) ? (longint'(rh) - r) : r;
      end
      v.x = sat20(vx); v.y = sat20(vy); v.ok = 1;
      return v;
    endfunction

    function void note_index(logic [9:0] idx);
      pending_q.push_back(rotate_vertex(idx));
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp_v;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex beat %h", got);
        return;
      end
      exp_v = pending_q.pop_front();
      if (got.x !== exp_v.x || got.y !== exp_v.y || got.color !== exp_v.color ||
          got.ok !== exp_v.ok) begin
        errors++;
        if (errors <= 10)
          $display("vertex mismatch: exp x=%h y=%h c=%h ok=%b  got x=%h y=%h c=%h ok=%b",
                   exp_v.x, exp_v.y, exp_v.color, exp_v.ok,
                   got.x, got.y, got.color, got.ok);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  rrov_in_if  in_ch();
  rrov_out_if out_ch();

  vertex_scoreboard sb;
  int  cycles = 0;
  int  burst_left;
  bit  hold_req;

  rounded_rect_outline_vertex_gen #(.MAX_QUALITY(MaxQual), .CORDIC_STAGES(NumStages)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_rounded_rect_outline_vertex_gen failed");
      $finish;
    end
  end

  // Receiver: stall pattern changes every so often; long hold on request.
  initial begin
    int      mode_left, pat, hold_cnt;
    vertex_t got;
    bit      take;
    bit      hold_done;
    mode_left = 0; pat = 0; hold_cnt = 0; hold_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_cnt = 400;
      end
      if (mode_left == 0) begin
        pat = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        case (pat)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= (cycles % 4 != 0);
          default: out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
      #1;
      take = out_ch.valid && out_ch.ready && rst_n;
      got = '{out_ch.vertex_x, out_ch.vertex_y, out_ch.vertex_color, out_ch.index_valid};
      @(posedge clk);
      if (take) sb.check_vertex(got);
    end
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  task automatic send_index(logic [9:0] idx);
    bit hs;
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.vertex_index <= idx;
    forever begin
      #1;
      hs = in_ch.ready;
      @(posedge clk);
      if (hs) break;
      @(negedge clk);
    end
    sb.note_index(idx);
  endtask

  // Drop valid and wait for every vertex to drain.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_shape(logic mode, logic [19:0] x0, logic [19:0] y0, logic [18:0] w,
                           logic [18:0] h, logic [17:0] r, logic [10:0] q, logic [31:0] c);
    write_cfg(REG_SHAPE_MODE, 32'(mode));
    write_cfg(REG_POS_X, 32'(x0));
    write_cfg(REG_POS_Y, 32'(y0));
    write_cfg(REG_RECT_WIDTH, 32'(w));
    write_cfg(REG_RECT_HEIGHT, 32'(h));
    write_cfg(REG_ARC_RADIUS, 32'(r));
    write_cfg(REG_QUALITY, 32'(q));
    write_cfg(REG_FILL_COLOR, c);
  endtask

  function automatic logic [9:0] pick_index();
    if ($urandom_range(0, 9) < 8) return 10'($urandom_range(0, sb.eff_quality() - 1));
    return 10'($urandom_range(0, 1023));
  endfunction

  initial begin
    logic [10:0] q;
    logic [17:0] r;
    sb = new();
    burst_left = 0; hold_req = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.vertex_index = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Four quadrants at full radius, then an index past the turn.
    set_shape(0, 20'd0, 20'd0, 19'd0, 19'd0, 18'h3FFFF, 11'd4, 32'h12345678);
    for (int i = 0; i <= 4; i++) send_index(10'(i));
    drain();
    // Quality not a multiple of four: last corner clamps; origin saturates high.
    set_shape(1, 20'h7FFFF, 20'h7FFFF, 19'h7FFFF, 19'h7FFFF, 18'd1000, 11'd10, 32'h0);
    send_index(10'd0); send_index(10'd5); send_index(10'd8);
    send_index(10'd9); send_index(10'd10);
    drain();
    // Quality below range clamps to four; radius beyond size, origin saturates low.
    set_shape(1, 20'h80000, 20'h80000, 19'd0, 19'd0, 18'h3FFFF, 11'd0, 32'hA5A5A5A5);
    for (int i = 0; i < 4; i++) send_index(10'(i));
    drain();
    // Quality above range clamps to the maximum.
    set_shape(0, 20'h00100, 20'hFFF00, 19'd0, 19'd0, 18'd4096, 11'h7FF, 32'hFFFFFFFF);
    send_index(10'd0); send_index(10'd255); send_index(10'd511); send_index(10'd1023);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      q = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                      : 11'($urandom_range(4, 1024));
      r = ($urandom_range(0, 5) == 0) ? 18'h3FFFF : 18'($urandom_range(0, 262143));
      set_shape(1'($urandom_range(0, 1)), 20'($urandom), 20'($urandom),
                19'($urandom), 19'($urandom), r, q, $urandom);
      if (ph == 4) hold_req = 1;
      for (int n = 0; n < 50; n++) send_index(pick_index());
      drain();
    end

    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("tb_rounded_rect_outline_vertex_gen passed");
    else
      $display("tb_rounded_rect_outline_vertex_gen failed");
    $finish;
  end
endmodule
